// ===== rtl/mgr2x_pkg.sv =====
// Shared constants, types and weight table for the 2x restriction block.
`timescale 1ns / 1ps
package mgr2x_pkg;

    localparam int MAX_PAIRS   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int LINE_DEPTH  = 2 * MAX_PAIRS + 1;
    localparam int POS_BITS    = $clog2(LINE_DEPTH);
    localparam int PAIR_BITS   = 11;
    localparam int WGT_BITS    = 17;
    localparam int PROD_BITS   = SAMPLE_BITS + WGT_BITS + 1;
    localparam int ACC_BITS    = PROD_BITS + 4;
    localparam int FRAC_BITS   = 16;

    localparam logic [1:0] CFG_PAIRS_ACROSS = 2'd0;
    localparam logic [1:0] CFG_PAIRS_DOWN   = 2'd1;
    localparam logic [1:0] CFG_MODE         = 2'd2;

    localparam logic [1:0] MODE_FULL   = 2'd0;
    localparam logic [1:0] MODE_HALF   = 2'd1;
    localparam logic [1:0] MODE_INJECT = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [PROD_BITS-1:0]   t_prod;

    // control for one item leaving the input stage
    typedef struct packed {
        logic       emit;
        logic [1:0] mode;
        logic [1:0] cls;      // number of border directions of the coarse point
        logic       r_odd;
        logic       c_odd;
        logic       top_ok;   // row above the coarse point exists
        logic       left_ok;  // column left of the coarse point exists
        logic       row_end;
        logic       grid_end;
    } t_ctl;

    // kind: 0 center, 1 orthogonal, 2 diagonal
    function automatic logic [WGT_BITS-1:0] weight_of(input logic [1:0] mode,
                                                      input logic [1:0] cls,
                                                      input logic [1:0] kind);
        logic [WGT_BITS-1:0] w;
        w = '0;
        case (mode)
            MODE_FULL: begin
                case ({cls, kind})
                    4'b0000: w = 17'd16384;
                    4'b0001: w = 17'd8192;
                    4'b0010: w = 17'd4096;
                    4'b0100: w = 17'd21823;
                    4'b0101: w = 17'd10918;
                    4'b0110: w = 17'd5461;
                    4'b1000: w = 17'd29098;
                    4'b1001: w = 17'd14549;
                    4'b1010: w = 17'd7274;
                    default: w = '0;
                endcase
            end
            MODE_HALF: begin
                case ({cls, kind})
                    4'b0000: w = 17'd21843;
                    4'b0001: w = 17'd10922;
                    4'b0100: w = 17'd26214;
                    4'b0101: w = 17'd13107;
                    4'b1000: w = 17'd32768;
                    4'b1001: w = 17'd16384;
                    default: w = '0;
                endcase
            end
            default: begin
                // injection: unit weight on the center passes the sample through
                w = (kind == 2'd0) ? 17'd65536 : '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/mgr2x_ram.sv =====
// Generic simple dual-port RAM, read-first, registered read with enable.
`timescale 1ns / 1ps
module mgr2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2049
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/mgr2x_window.sv =====
// 3x3 tap window over three fine rows, tap masking and registered products.
`timescale 1ns / 1ps
module mgr2x_window
    import mgr2x_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_sample i_sample,
    input  t_sample i_upper,
    input  t_sample i_middle,
    input  t_ctl    i_ctl,
    output logic    o_valid,
    output logic    o_row_end,
    output logic    o_grid_end,
    output t_prod   o_prod [9]
);
    // [0] newest column, [2] two columns back
    t_sample r_cur [3], r_prv [3], r_old [3];
    t_sample n_cur [3], n_prv [3], n_old [3];
    t_prod   n_prod [9];
    t_prod   r_prod [9];
    logic    r_valid, r_row_end, r_grid_end;

    always_comb begin
        t_sample t;
        t_sample p_in, q_in;
        logic    use_tap;
        int      ri, ci;
        logic [1:0] kind;
        logic signed [WGT_BITS:0] w;
        p_in = i_ctl.r_odd ? i_middle : i_upper;
        q_in = i_upper;
        n_cur[0] = i_sample; n_cur[1] = r_cur[0]; n_cur[2] = r_cur[1];
        n_prv[0] = p_in;     n_prv[1] = r_prv[0]; n_prv[2] = r_prv[1];
        n_old[0] = q_in;     n_old[1] = r_old[0]; n_old[2] = r_old[1];
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                use_tap = 1'b1;
                if (dr == 0 && !i_ctl.top_ok) use_tap = 1'b0;
                if (dr == 2 && !i_ctl.r_odd) use_tap = 1'b0;
                if (dc == 0 && !i_ctl.left_ok) use_tap = 1'b0;
                if (dc == 2 && !i_ctl.c_odd) use_tap = 1'b0;
                // column slot: odd column centers on slot 1, last column on slot 0
                ci = i_ctl.c_odd ? (2 - dc) : (1 - dc);
                if (ci < 0) ci = 0;
                ri = i_ctl.r_odd ? dr : dr + 1;
                case (ri)
                    0:       t = n_old[ci];
                    1:       t = n_prv[ci];
                    default: t = n_cur[ci];
                endcase
                kind = 2'((dr != 1 ? 1 : 0) + (dc != 1 ? 1 : 0));
                w = $signed({1'b0, weight_of(i_ctl.mode, i_ctl.cls, kind)});
                if (use_tap) begin
                    n_prod[dr*3+dc] = PROD_BITS'(t * w);
                end else begin
                    n_prod[dr*3+dc] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_cur[k] <= '0;
                r_prv[k] <= '0;
                r_old[k] <= '0;
            end
        end else if (i_en) begin
            r_valid <= i_valid && i_ctl.emit;
            if (i_valid) begin
                r_cur <= n_cur;
                r_prv <= n_prv;
                r_old <= n_old;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod     <= n_prod;
            r_row_end  <= i_ctl.row_end;
            r_grid_end <= i_ctl.grid_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_row_end  = r_row_end;
    assign o_grid_end = r_grid_end;
    assign o_prod     = r_prod;
endmodule

// ===== rtl/mgr2x_sum.sv =====
// Sums the nine products, rounds to nearest and saturates into the result register.
`timescale 1ns / 1ps
module mgr2x_sum
    import mgr2x_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  logic    i_row_end,
    input  logic    i_grid_end,
    input  t_prod   i_prod [9],
    output logic    o_valid,
    output logic    o_row_end,
    output logic    o_grid_end,
    output t_sample o_sample
);
    localparam int Q_BITS = ACC_BITS - FRAC_BITS;
    localparam logic signed [Q_BITS-1:0] SAT_HI = Q_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_BITS-1:0] SAT_LO = -SAT_HI - Q_BITS'(1);

    logic signed [ACC_BITS-1:0] acc, rnd;
    logic signed [Q_BITS-1:0]   q;
    t_sample                    n_sample, r_sample;
    logic                       r_valid, r_row_end, r_grid_end;

    always_comb begin
        acc = '0;
        for (int k = 0; k < 9; k++) begin
            acc = acc + ACC_BITS'(i_prod[k]);
        end
        rnd = acc + ACC_BITS'(1 << (FRAC_BITS - 1));
        q   = Q_BITS'(rnd >>> FRAC_BITS);
        if (q > SAT_HI) n_sample = SAT_HI[SAMPLE_BITS-1:0];
        else if (q < SAT_LO) n_sample = SAT_LO[SAMPLE_BITS-1:0];
        else n_sample = q[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sample   <= n_sample;
            r_row_end  <= i_row_end;
            r_grid_end <= i_grid_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_row_end  = r_row_end;
    assign o_grid_end = r_grid_end;
    assign o_sample   = r_sample;
endmodule

// ===== rtl/multigrid_restrict_2x_top.sv =====
// Top level of the streaming 2x multigrid restriction block.
`timescale 1ns / 1ps
// Fine samples enter in raster order on a (2A+1) x (2D+1) grid; coarse samples leave in
// raster order, one per coarse point, in full weighting, half weighting or injection mode.
// One fine beat is taken per clock while the output side is not stalled. The fine beat that
// completes a coarse result passes through the input stage with line memory read, the product
// stage and the sum and saturate stage in that order. Two line memories of 2*MAX_PAIRS+1
// entries hold the latest odd and even fine rows. A write to any of the three defined
// registers restarts the grid at its first sample; write only while the block is idle.
module multigrid_restrict_2x_top
    import mgr2x_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    // fine stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] fine_sample
    // coarse stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] coarse_sample
    output logic        m_axis_tlast,   // row_end
    output logic [0:0]  m_axis_tuser    // [0] grid_end
);
    logic [PAIR_BITS-1:0] r_pairs_across, r_pairs_down;
    logic [1:0]           r_mode;
    logic [POS_BITS-1:0]  r_col, r_row;
    logic [POS_BITS-1:0]  n_col, n_row, c, r;
    logic [POS_BITS-1:0]  last_col, last_row;
    logic [PAIR_BITS-1:0] pa, pd;
    logic [1:0]           mode;
    logic                 en, accept, cfg_hit;
    t_ctl                 n_ctl, r1_ctl;
    t_sample              r1_sample, upper_rd, middle_rd;
    logic                 r1_valid;
    logic                 w_valid, w_row_end, w_grid_end;
    t_prod                w_prod [9];
    logic                 s_valid, s_row_end, s_grid_end;
    t_sample              s_sample;

    function automatic logic [PAIR_BITS-1:0] clamp_pairs(input logic [PAIR_BITS-1:0] p);
        if (p == '0) return PAIR_BITS'(1);
        if (p > PAIR_BITS'(MAX_PAIRS)) return PAIR_BITS'(MAX_PAIRS);
        return p;
    endfunction

    assign pa       = clamp_pairs(r_pairs_across);
    assign pd       = clamp_pairs(r_pairs_down);
    assign last_col = POS_BITS'({pa, 1'b0});
    assign last_row = POS_BITS'({pd, 1'b0});
    assign mode     = (r_mode >= MODE_INJECT) ? MODE_INJECT : r_mode;

    assign o_cfg_ready   = 1'b1;
    assign cfg_hit       = i_cfg_valid && (i_cfg_index == CFG_PAIRS_ACROSS ||
                           i_cfg_index == CFG_PAIRS_DOWN || i_cfg_index == CFG_MODE);
    assign en            = !s_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    always_comb begin
        logic col_edge, row_edge;
        if (r_col > last_col || r_row > last_row) begin
            c = '0;
            r = '0;
        end else begin
            c = r_col;
            r = r_row;
        end
        col_edge = (c <= POS_BITS'(1)) || (c == last_col);
        row_edge = (r <= POS_BITS'(1)) || (r == last_row);
        n_ctl.mode     = mode;
        n_ctl.cls      = 2'(col_edge) + 2'(row_edge);
        n_ctl.r_odd    = r[0];
        n_ctl.c_odd    = c[0];
        n_ctl.top_ok   = r > POS_BITS'(1);
        n_ctl.left_ok  = c > POS_BITS'(1);
        n_ctl.row_end  = c == last_col;
        n_ctl.grid_end = (c == last_col) && (r == last_row);
        if (mode == MODE_INJECT) begin
            n_ctl.emit = !c[0] && !r[0];
        end else begin
            n_ctl.emit = (c[0] || c == last_col) && (r[0] || r == last_row);
        end
        if (c == last_col) begin
            n_col = '0;
            n_row = (r == last_row) ? '0 : r + POS_BITS'(1);
        end else begin
            n_col = c + POS_BITS'(1);
            n_row = r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs_across <= PAIR_BITS'(1);
            r_pairs_down   <= PAIR_BITS'(1);
            r_mode         <= MODE_FULL;
            r_col          <= '0;
            r_row          <= '0;
            r1_valid       <= 1'b0;
        end else begin
            if (cfg_hit) begin
                case (i_cfg_index)
                    CFG_PAIRS_ACROSS: r_pairs_across <= i_cfg_data;
                    CFG_PAIRS_DOWN:   r_pairs_down   <= i_cfg_data;
                    default:          r_mode         <= i_cfg_data[1:0];
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (en) begin
                r1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_sample <= s_axis_tdata;
            r1_ctl    <= n_ctl;
        end
    end

    // line memories: read-first gives the same-parity row two back at the written column
    mgr2x_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_DEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (accept && r[0]),
        .i_waddr (c),
        .i_wdata (s_axis_tdata),
        .i_re    (accept),
        .i_raddr (c),
        .o_rdata (upper_rd)
    );

    mgr2x_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_DEPTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (accept && !r[0]),
        .i_waddr (c),
        .i_wdata (s_axis_tdata),
        .i_re    (accept),
        .i_raddr (c),
        .o_rdata (middle_rd)
    );

    mgr2x_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r1_valid),
        .i_sample   (r1_sample),
        .i_upper    (upper_rd),
        .i_middle   (middle_rd),
        .i_ctl      (r1_ctl),
        .o_valid    (w_valid),
        .o_row_end  (w_row_end),
        .o_grid_end (w_grid_end),
        .o_prod     (w_prod)
    );

    mgr2x_sum u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (w_valid),
        .i_row_end  (w_row_end),
        .i_grid_end (w_grid_end),
        .i_prod     (w_prod),
        .o_valid    (s_valid),
        .o_row_end  (s_row_end),
        .o_grid_end (s_grid_end),
        .o_sample   (s_sample)
    );

    assign m_axis_tvalid   = s_valid;
    assign m_axis_tdata    = s_sample;
    assign m_axis_tlast    = s_row_end;
    assign m_axis_tuser[0] = s_grid_end;
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the streaming 2x multigrid restriction block.
`timescale 1ns / 1ps
module tb_top;
    import mgr2x_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [10:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    multigrid_restrict_2x_top dut (.*);

    typedef struct packed {
        logic [15:0] sample;
        logic        row_end;
        logic        grid_end;
    } t_coarse;

    // full / half weighting by border class and tap kind (center, orthogonal, diagonal)
    localparam longint KERNEL_WT [0:1][0:2][0:2] = '{
        '{'{16384, 8192, 4096}, '{21823, 10918, 5461}, '{29098, 14549, 7274}},
        '{'{21843, 10922, 0},   '{26214, 13107, 0},    '{32768, 16384, 0}}
    };

    t_sample     fine_q[$];
    t_coarse     coarse_q[$];
    int          errors = 0;
    int          n_fine = 0;
    int          n_coarse = 0;
    int          n_cfg = 0;
    bit          no_idle = 0;
    int          src_wait = 0;
    int          snk_wait = 0;

    // predictor state
    int unsigned p_across = 1, p_down = 1, p_mode = 0;
    longint      odd_row_mem  [0:LINE_DEPTH-1];
    longint      even_row_mem [0:LINE_DEPTH-1];
    longint      prev1, prev2;
    int unsigned cur_col, cur_row;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_pairs(input int unsigned p);
        if (p < 1) return 1;
        if (p > MAX_PAIRS) return MAX_PAIRS;
        return p;
    endfunction

    function automatic longint fine_at(input int unsigned row, input int unsigned col,
                                       input longint cur);
        if (row == cur_row) begin
            if (col == cur_col) return cur;
            if (col + 1 == cur_col) return prev1;
            return prev2;
        end
        return (row & 1) ? odd_row_mem[col] : even_row_mem[col];
    endfunction

    function automatic longint restrict_sum(input int unsigned cx, input int unsigned cy,
                                            input int unsigned lc, input int unsigned lr,
                                            input int unsigned m, input longint cur);
        int unsigned cls;
        longint      acc, w, t, q;
        cls = 0;
        acc = 0;
        if (cx == 0 || cx == lc) cls++;
        if (cy == 0 || cy == lr) cls++;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                w = KERNEL_WT[m][cls][int'(dr != 0) + int'(dc != 0)];
                if (w == 0) continue;
                if (dr < 0 && cy == 0) continue;
                if (dr > 0 && cy == lr) continue;
                if (dc < 0 && cx == 0) continue;
                if (dc > 0 && cx == lc) continue;
                acc += w * fine_at(cy + dr, cx + dc, cur);
            end
        end
        t = acc + 32768;
        q = t >>> FRAC_BITS;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    // advance the predictor by one fine beat, queue the coarse sample it completes
    task automatic predict_restrict(input t_sample s);
        int unsigned lc, lr, m, c, r, cx, cy;
        bit          emit;
        longint      v;
        t_coarse     e;
        lc = 2 * clamp_pairs(p_across);
        lr = 2 * clamp_pairs(p_down);
        m  = (p_mode >= MODE_INJECT) ? MODE_INJECT : p_mode;
        c  = cur_col;
        r  = cur_row;
        v  = 0;
        cx = c;
        cy = r;
        if (m == MODE_INJECT) begin
            emit = !(c & 1) && !(r & 1);
            v = s;
        end else begin
            emit = ((c & 1) || c == lc) && ((r & 1) || r == lr);
            if (emit) begin
                cx = (c & 1) ? c - 1 : c;
                cy = (r & 1) ? r - 1 : r;
                v = restrict_sum(cx, cy, lc, lr, m, s);
            end
        end
        if (emit) begin
            e.sample   = v[15:0];
            e.row_end  = (cx == lc);
            e.grid_end = (cx == lc) && (cy == lr);
            coarse_q.push_back(e);
        end
        // lines trail the stream by two columns
        if (r & 1) begin
            if (c >= 2) odd_row_mem[c-2] = prev2;
            if (c == lc) begin
                odd_row_mem[c-1] = prev1;
                odd_row_mem[c]   = s;
            end
        end else begin
            if (c >= 2) even_row_mem[c-2] = prev2;
            if (c == lc) begin
                even_row_mem[c-1] = prev1;
                even_row_mem[c]   = s;
            end
        end
        prev2 = prev1;
        prev1 = s;
        if (c == lc) begin
            cur_col = 0;
            cur_row = (r == lr) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_PAIRS_ACROSS: p_across = val;
            CFG_PAIRS_DOWN:   p_down = val;
            CFG_MODE:         p_mode = val[1:0];
            default: ;
        endcase
        if (idx != 2'd3) begin
            cur_col = 0;
            cur_row = 0;
        end
    endtask

    // sampled at the falling edge so the clocked blocks have settled
    task automatic wait_idle();
        while (fine_q.size() != 0 || s_axis_tvalid || coarse_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return t_sample'($urandom_range(0, 15)) - t_sample'(8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // stimulus: fills the fine queue phase by phase
    initial begin
        int unsigned a, d, grid, cnt;
        logic [10:0] va, vd;
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        prev1 = 0;
        prev2 = 0;
        cur_col = 0;
        cur_row = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: 3x3 full weighting, saturating and extreme values
        repeat (9) fine_q.push_back(16'sh7fff);
        repeat (9) fine_q.push_back(16'sh8000);
        for (int i = 0; i < 7; i++) fine_q.push_back((i & 1) ? 16'sh8000 : 16'sh7fff);
        wait_idle();

        // each mode on a 5x3 grid, plus out-of-range index and clamped counts
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_MODE, {9'h1ff, 2'(m)});
            write_reg(CFG_PAIRS_ACROSS, 11'd2);
            write_reg(CFG_PAIRS_DOWN, (m == 3) ? 11'd0 : 11'd1);
            write_reg(2'd3, 11'h5a5);
            repeat (15) fine_q.push_back(rand_sample());
            wait_idle();
        end

        // oversized width clamps to the largest one: start of a wide row in injection
        write_reg(CFG_MODE, 11'(MODE_INJECT));
        write_reg(CFG_PAIRS_ACROSS, 11'h7ff);
        write_reg(CFG_PAIRS_DOWN, 11'd1);
        repeat (60) fine_q.push_back(rand_sample());
        wait_idle();

        cnt = 0;
        while (cnt < 1150) begin
            no_idle = ($urandom_range(0, 4) == 0);
            a = $urandom_range(1, 6);
            d = $urandom_range(1, 6);
            va = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'(a);
            vd = ($urandom_range(0, 19) == 0) ? 11'd0 : 11'(d);
            a = clamp_pairs(va);
            d = clamp_pairs(vd);
            write_reg(CFG_PAIRS_DOWN, vd);
            write_reg(CFG_MODE, 11'($urandom));
            write_reg(CFG_PAIRS_ACROSS, va);
            if ($urandom_range(0, 3) == 0) write_reg(2'd3, 11'($urandom));
            grid = (2 * a + 1) * (2 * d + 1);
            repeat ($urandom_range(1, 3) * grid + (($urandom_range(0, 2) == 0) ?
                    $urandom_range(0, grid - 1) : 0)) begin
                fine_q.push_back(rand_sample());
                cnt++;
            end
            wait_idle();
        end

        $display("Covered %0d fine beats, %0d coarse beats, %0d register writes,",
                 n_fine, n_coarse, n_cfg);
        $display("all three modes and the mode 3 alias, clamped and border sizes.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // fine stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_restrict(s_axis_tdata);
                n_fine++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    s_axis_tvalid <= 1'b0;
                    src_wait--;
                end else if (fine_q.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= fine_q.pop_front();
                    src_wait = no_idle ? 0 : $urandom_range(0, 19);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // coarse stream monitor and backpressure
    always @(posedge i_clk) begin
        t_coarse e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_coarse++;
                if (coarse_q.size() == 0) begin
                    $error("unexpected coarse beat %h", m_axis_tdata);
                    errors++;
                end else begin
                    e = coarse_q.pop_front();
                    if (m_axis_tdata !== e.sample) begin
                        $error("coarse_sample expected %0d got %0d",
                               $signed(e.sample), $signed(m_axis_tdata));
                        errors++;
                    end
                    if (m_axis_tlast !== e.row_end) begin
                        $error("row_end expected %0b got %0b", e.row_end, m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== e.grid_end) begin
                        $error("grid_end expected %0b got %0b", e.grid_end, m_axis_tuser[0]);
                        errors++;
                    end
                end
                snk_wait = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (snk_wait > 0) begin
                m_axis_tready <= 1'b0;
                snk_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
